@@ rtl/fi25519_pkg.sv @@
// Package for the p25519 field inverter: payload structs, field constants and
// the fixed exponentiation program. No dependencies.
package fi25519_pkg;

  localparam int LimbInW  = 52;
  localparam int LimbOutW = 51;
  localparam int FeW      = 255;            // canonical field element width
  localparam int RawW     = 257;            // raw operand width before reduction
  localparam int MulSteps = RawW;           // one multiplier bit per cycle
  localparam int CntW     = $clog2(MulSteps);

  localparam logic [FeW-1:0] P25519 =
    255'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFED;

  typedef struct packed {
    logic [LimbInW-1:0] z_limb4;
    logic [LimbInW-1:0] z_limb3;
    logic [LimbInW-1:0] z_limb2;
    logic [LimbInW-1:0] z_limb1;
    logic [LimbInW-1:0] z_limb0;
  } in_item_t;

  typedef struct packed {
    logic [LimbOutW-1:0] inv_limb4;
    logic [LimbOutW-1:0] inv_limb3;
    logic [LimbOutW-1:0] inv_limb2;
    logic [LimbOutW-1:0] inv_limb1;
    logic [LimbOutW-1:0] inv_limb0;
  } out_item_t;

  typedef enum logic [3:0] {
    R_ONE, R_RAW, R_Z, R_Z2, R_Z9, R_Z11, R_E5, R_E10, R_E20, R_E50, R_E100, R_T
  } reg_sel_t;

  typedef struct packed {
    reg_sel_t    x;
    reg_sel_t    y;
    reg_sel_t    dst;
    logic [6:0]  rep;   // first product, then rep-1 squarings of dst
  } op_t;

  localparam logic [4:0] LastPc = 5'd22;

  function automatic op_t prog(input logic [4:0] pc);
    op_t o;
    unique case (pc)
      5'd0:    o = '{R_RAW,  R_ONE,  R_Z,    7'd1};
      5'd1:    o = '{R_Z,    R_Z,    R_Z2,   7'd1};
      5'd2:    o = '{R_Z2,   R_Z2,   R_T,    7'd2};
      5'd3:    o = '{R_T,    R_Z,    R_Z9,   7'd1};
      5'd4:    o = '{R_Z9,   R_Z2,   R_Z11,  7'd1};
      5'd5:    o = '{R_Z11,  R_Z11,  R_T,    7'd1};
      5'd6:    o = '{R_T,    R_Z9,   R_E5,   7'd1};
      5'd7:    o = '{R_E5,   R_E5,   R_T,    7'd5};
      5'd8:    o = '{R_T,    R_E5,   R_E10,  7'd1};
      5'd9:    o = '{R_E10,  R_E10,  R_T,    7'd10};
      5'd10:   o = '{R_T,    R_E10,  R_E20,  7'd1};
      5'd11:   o = '{R_E20,  R_E20,  R_T,    7'd20};
      5'd12:   o = '{R_T,    R_E20,  R_T,    7'd1};
      5'd13:   o = '{R_T,    R_T,    R_T,    7'd10};
      5'd14:   o = '{R_T,    R_E10,  R_E50,  7'd1};
      5'd15:   o = '{R_E50,  R_E50,  R_T,    7'd50};
      5'd16:   o = '{R_T,    R_E50,  R_E100, 7'd1};
      5'd17:   o = '{R_E100, R_E100, R_T,    7'd100};
      5'd18:   o = '{R_T,    R_E100, R_T,    7'd1};
      5'd19:   o = '{R_T,    R_T,    R_T,    7'd50};
      5'd20:   o = '{R_T,    R_E50,  R_T,    7'd1};
      5'd21:   o = '{R_T,    R_T,    R_T,    7'd5};
      5'd22:   o = '{R_T,    R_Z11,  R_T,    7'd1};
      default: o = '{R_T,    R_Z11,  R_T,    7'd1};
    endcase
    return o;
  endfunction

endpackage

@@ rtl/fi25519_mul.sv @@
// Bit-serial modular multiplier modulo 2^255-19, multiplier bits MSB first.
// Depends on fi25519_pkg.
module fi25519_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [fi25519_pkg::RawW-1:0] a_i,
  input  logic [fi25519_pkg::FeW-1:0]  b_i,
  output logic                         done_o,
  output logic [fi25519_pkg::FeW-1:0]  res_o
);
  import fi25519_pkg::*;

  localparam logic [RawW-1:0] PExt  = {2'b00, P25519};
  localparam logic [RawW-1:0] P2Ext = {1'b0, P25519, 1'b0};

  logic [RawW-1:0] a_r;
  logic [FeW-1:0]  b_r, acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [RawW-1:0] sum;

  // double, add the multiplicand if the bit is set, bring back below p
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (a_r[RawW-1] ? {2'b00, b_r} : '0);
    if (sum >= P2Ext)      acc_nxt = FeW'(sum - P2Ext);
    else if (sum >= PExt)  acc_nxt = FeW'(sum - PExt);
    else                   acc_nxt = sum[FeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        a_r    <= a_i;
        b_r    <= b_i;
        acc_r  <= '0;
        cnt_r  <= CntW'(MulSteps - 1);
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[RawW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign res_o  = acc_r;

endmodule

@@ rtl/field_inverse_p25519_top.sv @@
// Top level of the p25519 field inverter: request handshakes, register bank
// and exponentiation sequencer. Depends on fi25519_pkg and fi25519_mul.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: five loose 52-bit limbs of z.
//   out_valid/out_ready/out_data return z^(p-2) mod p as five canonical
//   51-bit limbs; a zero operand returns zero.
//   One request is in flight at a time; in_ready is high only when idle.
//   Each request runs 266 modular products (one input reduction plus the
//   265-step addition chain) in the bit-serial multiplier, with a load
//   state before each product. The single shared multiplier serves one
//   request at a time: a new one is taken only after the last result left.
//   Reset (rst_n low, synchronous) drops any request in progress and
//   returns to idle; the bank needs no clearing.
//   When the receiver stalls, hold the result in the output register and
//   keep in_ready low until it is taken.
module field_inverse_p25519_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fi25519_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fi25519_pkg::out_item_t out_data
);
  import fi25519_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t          state_r;
  logic [4:0]      pc_r;
  logic [6:0]      rep_r;
  logic            sq_r;          // squaring the previous product
  logic [RawW-1:0] raw_r;
  logic [FeW-1:0]  z_r, z2_r, z9_r, z11_r, e5_r, e10_r, e20_r, e50_r, e100_r, t_r;
  out_item_t       out_r;

  op_t             op;
  logic [RawW-1:0] raw_sum;
  logic [RawW-1:0] opa;
  logic [FeW-1:0]  opb;
  logic            mul_start, mul_done;
  logic [FeW-1:0]  mul_res;

  function automatic logic [RawW-1:0] rd(input reg_sel_t s, input logic [RawW-1:0] raw,
      input logic [FeW-1:0] z, input logic [FeW-1:0] z2, input logic [FeW-1:0] z9,
      input logic [FeW-1:0] z11, input logic [FeW-1:0] e5, input logic [FeW-1:0] e10,
      input logic [FeW-1:0] e20, input logic [FeW-1:0] e50, input logic [FeW-1:0] e100,
      input logic [FeW-1:0] t);
    logic [RawW-1:0] v;
    unique case (s)
      R_ONE:   v = RawW'(1);
      R_RAW:   v = raw;
      R_Z:     v = {2'b00, z};
      R_Z2:    v = {2'b00, z2};
      R_Z9:    v = {2'b00, z9};
      R_Z11:   v = {2'b00, z11};
      R_E5:    v = {2'b00, e5};
      R_E10:   v = {2'b00, e10};
      R_E20:   v = {2'b00, e20};
      R_E50:   v = {2'b00, e50};
      R_E100:  v = {2'b00, e100};
      R_T:     v = {2'b00, t};
      default: v = '0;
    endcase
    return v;
  endfunction

  assign op = prog(pc_r);

  // weigh the loose limbs into one raw value; reduced by the first product
  assign raw_sum = RawW'(in_data.z_limb0)
                 + (RawW'(in_data.z_limb1) << LimbOutW)
                 + (RawW'(in_data.z_limb2) << (2 * LimbOutW))
                 + (RawW'(in_data.z_limb3) << (3 * LimbOutW))
                 + (RawW'(in_data.z_limb4) << (4 * LimbOutW));

  // on a repeat, square the destination; otherwise take the op's sources
  always_comb begin
    logic [RawW-1:0] ya;
    if (sq_r) begin
      opa = rd(op.dst, raw_r, z_r, z2_r, z9_r, z11_r, e5_r, e10_r, e20_r, e50_r, e100_r, t_r);
      ya  = opa;
    end else begin
      opa = rd(op.x, raw_r, z_r, z2_r, z9_r, z11_r, e5_r, e10_r, e20_r, e50_r, e100_r, t_r);
      ya  = rd(op.y, raw_r, z_r, z2_r, z9_r, z11_r, e5_r, e10_r, e20_r, e50_r, e100_r, t_r);
    end
    opb = ya[FeW-1:0];
  end

  assign mul_start = (state_r == S_LOAD);

  fi25519_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      rep_r   <= '0;
      sq_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            raw_r   <= raw_sum;
            pc_r    <= '0;
            rep_r   <= prog(5'd0).rep;
            sq_r    <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            // write back the product
            unique case (op.dst)
              R_Z:     z_r    <= mul_res;
              R_Z2:    z2_r   <= mul_res;
              R_Z9:    z9_r   <= mul_res;
              R_Z11:   z11_r  <= mul_res;
              R_E5:    e5_r   <= mul_res;
              R_E10:   e10_r  <= mul_res;
              R_E20:   e20_r  <= mul_res;
              R_E50:   e50_r  <= mul_res;
              R_E100:  e100_r <= mul_res;
              default: t_r    <= mul_res;
            endcase
            if (rep_r > 7'd1) begin
              rep_r   <= rep_r - 7'd1;
              sq_r    <= 1'b1;
              state_r <= S_LOAD;
            end else if (pc_r == LastPc) begin
              out_r.inv_limb0 <= mul_res[LimbOutW-1:0];
              out_r.inv_limb1 <= mul_res[2*LimbOutW-1:LimbOutW];
              out_r.inv_limb2 <= mul_res[3*LimbOutW-1:2*LimbOutW];
              out_r.inv_limb3 <= mul_res[4*LimbOutW-1:3*LimbOutW];
              out_r.inv_limb4 <= mul_res[5*LimbOutW-1:4*LimbOutW];
              state_r         <= S_OUT;
            end else begin
              pc_r    <= pc_r + 5'd1;
              rep_r   <= prog(pc_r + 5'd1).rep;
              sq_r    <= 1'b0;
              state_r <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOAD)
    else $error("accepted request did not start the sequence");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_WAIT)
    else $error("product finished outside the wait state");

  a_out_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pc_r == LastPc)
    else $error("result offered before the last step");

endmodule

@@ tb/tb_field_inverse_p25519_top.sv @@
// Testbench for field_inverse_p25519_top: drives operands through the request
// channel and checks each canonical inverse against a predictor built on
// plain modular exponentiation. Depends on fi25519_pkg and the RTL top level.
module tb_field_inverse_p25519_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fi25519_pkg::*;

  localparam int NumRandom = 90;
  localparam int CalmFrom  = 80;   // no idling from this request onwards

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic      stalls_on;
  int        stall_left;

  field_inverse_p25519_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Holds the inverses still owed by the block, oldest first.
  class inverse_board;
    out_item_t owed[$];
    int        mismatches;

    // Fold the loose limbs into one value and raise it to p-2 modulo p.
    function automatic out_item_t fermat_inverse(in_item_t d);
      logic [511:0] modulus;
      logic [511:0] base;
      logic [511:0] acc;
      logic [254:0] expo;
      out_item_t    res;
      modulus = {257'b0, P25519};
      expo    = P25519 - 255'd2;
      base    = {460'b0, d.z_limb0} + ({460'b0, d.z_limb1} << 51) +
                ({460'b0, d.z_limb2} << 102) + ({460'b0, d.z_limb3} << 153) +
                ({460'b0, d.z_limb4} << 204);
      base    = base % modulus;
      acc     = 512'd1;
      for (int i = 254; i >= 0; i--) begin
        acc = (acc * acc) % modulus;
        if (expo[i]) begin
          acc = (acc * base) % modulus;
        end
      end
      res.inv_limb0 = acc[50:0];
      res.inv_limb1 = acc[101:51];
      res.inv_limb2 = acc[152:102];
      res.inv_limb3 = acc[203:153];
      res.inv_limb4 = acc[254:204];
      return res;
    endfunction

    function void note_request(in_item_t d);
      owed.push_back(fermat_inverse(d));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (owed.size() == 0) begin
        report("unexpected result", 64'(r.inv_limb0), 64'd0);
        return;
      end
      e = owed.pop_front();
      if (r.inv_limb0 !== e.inv_limb0) report("inv_limb0", 64'(r.inv_limb0), 64'(e.inv_limb0));
      if (r.inv_limb1 !== e.inv_limb1) report("inv_limb1", 64'(r.inv_limb1), 64'(e.inv_limb1));
      if (r.inv_limb2 !== e.inv_limb2) report("inv_limb2", 64'(r.inv_limb2), 64'(e.inv_limb2));
      if (r.inv_limb3 !== e.inv_limb3) report("inv_limb3", 64'(r.inv_limb3), 64'(e.inv_limb3));
      if (r.inv_limb4 !== e.inv_limb4) report("inv_limb4", 64'(r.inv_limb4), 64'(e.inv_limb4));
    endtask
  endclass

  inverse_board board = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both handshakes; values read here are those from before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_request(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_data);
    end
  end

  // Result side: drop ready in short random bursts while stalls are allowed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [51:0] rand_limb();
    return {20'($urandom_range(0, 1048575)), $urandom()};
  endfunction

  // Split a value below 2^256 into radix-2^51 limbs, the top limb taking the rest.
  function automatic in_item_t split_limbs(logic [255:0] v);
    in_item_t d;
    d.z_limb0 = {1'b0, v[50:0]};
    d.z_limb1 = {1'b0, v[101:51]};
    d.z_limb2 = {1'b0, v[152:102]};
    d.z_limb3 = {1'b0, v[203:153]};
    d.z_limb4 = v[255:204];
    return d;
  endfunction

  // Present one request and hold it until taken; leave valid high afterwards.
  task send_request(in_item_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    in_item_t     directed[$];
    in_item_t     d;
    logic [255:0] p256;
    int           sent;
    int           drain;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    stalls_on <= 1'b1;
    sent       = 0;
    p256       = {1'b0, P25519};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and its aliases p and 2p, the unit and p+1, p-1, loose limbs and two.
    directed.push_back('0);
    directed.push_back(split_limbs(p256));
    directed.push_back(split_limbs(p256 << 1));
    directed.push_back(split_limbs(256'd1));
    directed.push_back(split_limbs(p256 - 256'd1));
    directed.push_back(split_limbs(p256 + 256'd1));
    d = '1;
    directed.push_back(d);
    d = '0;
    d.z_limb4 = '1;
    directed.push_back(d);
    d = '0;
    d.z_limb0 = '1;
    directed.push_back(d);
    d = '0;
    d.z_limb2 = 52'h8000000000000;
    directed.push_back(d);
    directed.push_back(split_limbs(256'd2));

    foreach (directed[i]) begin
      send_request(directed[i]);
      sent++;
      if ($urandom_range(0, 1) == 0) idle_gap($urandom_range(1, 3));
    end

    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          // Hover just around p so the wrap is exercised.
          d = split_limbs(p256 + 256'($urandom_range(0, 40)) - 256'd20);
        end
        1: begin
          // Canonical limbs only.
          d.z_limb0 = rand_limb() & 52'h7FFFFFFFFFFFF;
          d.z_limb1 = rand_limb() & 52'h7FFFFFFFFFFFF;
          d.z_limb2 = rand_limb() & 52'h7FFFFFFFFFFFF;
          d.z_limb3 = rand_limb() & 52'h7FFFFFFFFFFFF;
          d.z_limb4 = rand_limb() & 52'h7FFFFFFFFFFFF;
        end
        default: begin
          d.z_limb0 = rand_limb();
          d.z_limb1 = rand_limb();
          d.z_limb2 = rand_limb();
          d.z_limb3 = rand_limb();
          d.z_limb4 = rand_limb();
        end
      endcase
      send_request(d);
      sent++;
      if (sent >= CalmFrom) begin
        stalls_on <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        idle_gap($urandom_range(1, 3));
      end
    end
    in_valid <= 1'b0;
    // let the monitor note the last request before waiting on the queue
    @(posedge clk);

    while (board.owed.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk);
      drain++;
    end

    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Allow several times the slowest expected run before giving up.
  initial begin
    #300ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
